FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

FILE: hw/rtl/art_pkg.sv
`timescale 1ns / 1ps

package art_pkg;

    localparam int unsigned TABLE_ENTRIES = 16;

    localparam int unsigned UID_W  = 32;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned FUNC_W = 2;

    // slot address and scan counter (counter reaches TABLE_ENTRIES)
    localparam int unsigned ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);

    // memory word: {mask, user}
    localparam int unsigned MEM_W = UID_W + MASK_W;

    // stream payload widths (whole bytes)
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GRANT  = 2'd0,
        FUNC_REVOKE = 2'd1,
        FUNC_CHECK  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

FILE: hw/rtl/access_rights_table.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake                Payload
// s (req)   in   i_s_tvalid/o_s_tready   tuser: func; tdata: user_id, rights
// m (rsp)   out  o_m_tvalid/i_m_tready   tdata: allowed, status
// cfg       in   i_cfg_we                i_cfg_wdata: owner_uid
//
// Each request makes one read of the table memory per slot, then drains the
// last compare, then does the write-back and result load in the DONE state.
// The single-port slot memory is why the slots are read one by one.
// Reset (i_rst_n, synchronous, low) clears all valid bits and the owner id.
// The next request is taken while a result still waits in the output
// register; the write-back cycle holds only if that register is still full.

module access_rights_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request item
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [art_pkg::S_TDATA_W-1:0]  i_s_tdata,  // [31:0] user_id, [34:32] rights, rest 0
    input  logic [art_pkg::FUNC_W-1:0]     i_s_tuser,  // [1:0] func
    // response item
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [art_pkg::M_TDATA_W-1:0]  o_m_tdata,  // [0] allowed, [1] status, rest 0
    // owner id register
    input  logic                           i_cfg_we,
    input  logic [art_pkg::UID_W-1:0]      i_cfg_wdata
);

    localparam int unsigned N      = art_pkg::TABLE_ENTRIES;
    localparam int unsigned AW     = art_pkg::ADDR_W;
    localparam int unsigned CW     = art_pkg::CNT_W;
    localparam int unsigned UW     = art_pkg::UID_W;
    localparam int unsigned MW     = art_pkg::MASK_W;
    localparam logic [CW-1:0] CNT_END = CW'(N);

    // ---------------- state ----------------
    art_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    // latched request
    art_pkg::t_func   r_func;
    logic [UW-1:0]    r_uid;
    logic [MW-1:0]    r_rights;

    // scan results
    logic             r_hit, n_hit;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic [MW-1:0]    r_hit_mask, n_hit_mask;
    logic             r_free, n_free;
    logic [AW-1:0]    r_free_idx, n_free_idx;

    // read pipeline: data for r_cmp_idx is in r_q when r_cmp_en
    logic             r_cmp_en;
    logic [AW-1:0]    r_cmp_idx;
    logic [art_pkg::MEM_W-1:0] r_q;

    // slot store: valid bits in flops, user/mask in memory
    logic [N-1:0]     r_valid;
    logic [art_pkg::MEM_W-1:0] r_mem [N];

    logic [UW-1:0]    r_owner_uid;

    // output register
    logic             r_out_valid;
    logic             r_out_allowed;
    logic             r_out_status;

    // ---------------- control ----------------
    logic             accept;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             out_load;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    logic             set_valid;
    logic             clr_valid;
    logic             n_allowed;
    logic             n_status;
    logic [UW-1:0]    q_user;
    logic [MW-1:0]    q_mask;

    assign o_s_tready = (r_state == art_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == art_pkg::S_DONE) && (!r_out_valid || i_m_tready);

    assign q_user = r_q[UW-1:0];
    assign q_mask = r_q[art_pkg::MEM_W-1:UW];

    // result of the finished scan; grant lands on the hit slot, else first free
    assign wr_idx = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        n_allowed = 1'b0;
        n_status  = 1'b0;
        wr_en     = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        unique case (r_func)
            art_pkg::FUNC_GRANT: begin
                if (r_hit || r_free) begin
                    wr_en     = out_load;
                    set_valid = out_load;
                end else begin
                    n_status  = 1'b1;   // table full, grant dropped
                end
            end
            art_pkg::FUNC_REVOKE: begin
                clr_valid = out_load && r_hit;
            end
            art_pkg::FUNC_CHECK: begin
                // stored mask covers the need, or owner with a nonempty need
                n_allowed = (r_hit && ((r_hit_mask & r_rights) == r_rights)) ||
                            ((r_uid == r_owner_uid) && (r_rights != '0));
            end
            default: begin
                // unused kind: no change, zero result
            end
        endcase
    end

    // scan sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        rd_en      = 1'b0;
        rd_addr    = r_cnt[AW-1:0];
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_mask = r_hit_mask;
        n_free     = r_free;
        n_free_idx = r_free_idx;

        unique case (r_state)
            art_pkg::S_IDLE: begin
                if (accept) begin
                    // slot 0 is read in the accept cycle
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_cnt   = CW'(1);
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_state = art_pkg::S_SCAN;
                end
            end
            art_pkg::S_SCAN: begin
                if (r_cnt < CNT_END) begin
                    rd_en = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_cmp_en) begin
                    // keep the first match and the first free slot
                    if (r_valid[r_cmp_idx] && (q_user == r_uid) && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_cmp_idx;
                        n_hit_mask = q_mask;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = art_pkg::S_DONE;
                end
            end
            art_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = art_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = art_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= art_pkg::S_IDLE;
            r_cnt       <= '0;
            r_cmp_en    <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_valid     <= '0;
            r_owner_uid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_cmp_en <= rd_en;
            r_hit    <= n_hit;
            r_free   <= n_free;
            if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end else if (clr_valid) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cfg_we) begin
                r_owner_uid <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= rd_addr;
        r_hit_idx  <= n_hit_idx;
        r_hit_mask <= n_hit_mask;
        r_free_idx <= n_free_idx;
        if (accept) begin
            r_func   <= art_pkg::t_func'(i_s_tuser);
            r_uid    <= i_s_tdata[UW-1:0];
            r_rights <= i_s_tdata[UW+MW-1:UW];
        end
        if (out_load) begin
            r_out_allowed <= n_allowed;
            r_out_status  <= n_status;
        end
    end

    // slot memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= {r_rights, r_uid};
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(art_pkg::M_TDATA_W-2){1'b0}}, r_out_status, r_out_allowed};

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_drop_only_full, i_clk, i_rst_n, out_load && n_status, &r_valid, "grant dropped with a free slot")
    `ASSERT_NXT(a_grant_sets_valid, i_clk, i_rst_n, set_valid, r_valid[$past(wr_idx)], "granted slot not valid")
    `ASSERT_NXT(a_revoke_clears, i_clk, i_rst_n, clr_valid, !r_valid[$past(r_hit_idx)], "revoked slot still valid")

endmodule

FILE: verif/access_rights_table_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the access-rights table.
// Requests go in on the s stream (func in tuser, user id and rights in tdata).
// One response per request comes out on the m stream. A scoreboard keeps its
// own copy of the slots and the owner id. It predicts allowed/status for
// every accepted request and checks responses in order.
module access_rights_table_tb;

    localparam int unsigned SLOTS = art_pkg::TABLE_ENTRIES;
    localparam logic [art_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;  // no kind assigned

    localparam int MAX_WAIT     = 18;    // longest gap / stall per item
    localparam int SETTLE       = 20;    // one request time plus margin
    localparam int DRAIN_CYCLES = 40;    // quiet time after the last response
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 213;
    localparam int POOL_SIZE    = 24;    // more ids than slots, so the table fills

    typedef struct {
        bit allowed;
        bit status;
    } rsp_t;

    // Predicts the response of each request from a private copy of the table.
    class rights_scoreboard;
        bit          slot_valid [SLOTS];
        logic [31:0] slot_user  [SLOTS];
        logic [2:0]  slot_mask  [SLOTS];
        logic [31:0] owner_uid;
        rsp_t        pending_rsp [$];
        int          n_requests;
        int          n_responses;
        int          n_dropped;
        int          n_allowed;
        int          n_errors;

        function void set_owner(logic [31:0] uid);
            owner_uid = uid;
        endfunction

        function int lookup(logic [31:0] uid);
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && slot_user[i] == uid) return i;
            end
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_valid[i]) return i;
            end
            return -1;
        endfunction

        function void note_request(logic [1:0] func, logic [31:0] uid, logic [2:0] rights);
            rsp_t r;
            int   idx;
            r.allowed = 1'b0;
            r.status  = 1'b0;
            idx = lookup(uid);
            case (func)
                art_pkg::FUNC_GRANT: begin
                    if (idx < 0) idx = first_free();
                    if (idx >= 0) begin
                        slot_valid[idx] = 1'b1;
                        slot_user[idx]  = uid;
                        slot_mask[idx]  = rights;
                    end else begin
                        r.status = 1'b1;
                        n_dropped++;
                    end
                end
                art_pkg::FUNC_REVOKE: begin
                    if (idx >= 0) slot_valid[idx] = 1'b0;
                end
                art_pkg::FUNC_CHECK: begin
                    // stored mask covers the need, or owner asking for something
                    if ((idx >= 0 && (slot_mask[idx] & rights) == rights) ||
                        (uid == owner_uid && rights != 3'd0)) begin
                        r.allowed = 1'b1;
                        n_allowed++;
                    end
                end
                default: ;  // unused kind: no change, all zero
            endcase
            n_requests++;
            pending_rsp.push_back(r);
        endfunction

        function void report(string field, int want, logic got);
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: response %0d, %s expected %0d got %b",
                         $time, n_responses, field, want, got);
        endfunction

        function void check_response(logic [art_pkg::M_TDATA_W-1:0] tdata);
            rsp_t want;
            n_responses++;
            if (pending_rsp.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: response %0d (%h) with no request outstanding",
                             $time, n_responses, tdata);
                return;
            end
            want = pending_rsp.pop_front();
            if (tdata[0] !== want.allowed) report("allowed", want.allowed, tdata[0]);
            if (tdata[1] !== want.status)  report("status", want.status, tdata[1]);
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [art_pkg::S_TDATA_W-1:0]  i_s_tdata   = '0;  // [31:0] user_id, [34:32] rights
    logic [art_pkg::FUNC_W-1:0]     i_s_tuser   = '0;  // [1:0] func
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [art_pkg::M_TDATA_W-1:0]  o_m_tdata;         // [0] allowed, [1] status
    logic                           i_cfg_we    = 1'b0;
    logic [art_pkg::UID_W-1:0]      i_cfg_wdata = '0;

    rights_scoreboard sb;
    bit               no_idle = 1'b0;   // both sides run back to back while set
    int               owner_writes = 0;
    int               quiet_cycles = 0;
    logic [31:0]      uid_pool [POOL_SIZE];

    access_rights_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a correct run never goes long without a handshake on one side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One request item. Valid is dropped only when a gap is drawn, so a
    // back-to-back item keeps valid high without a low/high pair in one step.
    task automatic send_request(input logic [1:0] func, input logic [31:0] uid,
                                input logic [2:0] rights);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, rights, uid};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(func, uid, rights);
    endtask

    // Response side: a fresh stall is drawn for every item.
    task automatic response_sink();
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_response(o_m_tdata);
        end
    endtask

    // Owner id is only written with nothing in flight. The last request was
    // just accepted, so valid drops here to keep it from being taken again.
    task automatic write_owner(input logic [31:0] uid);
        i_s_tvalid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= uid;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_owner(uid);
        owner_writes++;
    endtask

    // Owner is still 0 from reset here.
    task automatic run_directed();
        // owner on an empty table, with and without a needed mask
        send_request(art_pkg::FUNC_CHECK, 32'h0000_0000, 3'd7);
        send_request(art_pkg::FUNC_CHECK, 32'h0000_0000, 3'd0);
        // empty mask still takes a slot
        send_request(art_pkg::FUNC_GRANT, 32'hFFFF_FFFF, 3'd0);
        send_request(art_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 3'd0);
        send_request(art_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 3'd1);
        // revoke of a user that has no slot
        send_request(art_pkg::FUNC_REVOKE, 32'h1234_5678, 3'd5);
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 3'd7);
        // fill the remaining slots
        for (int k = 1; k < SLOTS; k++)
            send_request(art_pkg::FUNC_GRANT, 32'(k), 3'(k));
        // new user on a full table is dropped; update of a present user is not
        send_request(art_pkg::FUNC_GRANT, 32'hAAAA_5555, 3'd7);
        send_request(art_pkg::FUNC_GRANT, 32'hFFFF_FFFF, 3'd7);
        send_request(art_pkg::FUNC_REVOKE, 32'hFFFF_FFFF, 3'd0);
        send_request(art_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 3'd7);
    endtask

    // Mostly ids from a small pool so grants, revokes and checks hit each other.
    task automatic send_random(input int grant_pct, input int revoke_pct);
        int          pick;
        logic [1:0]  func;
        logic [31:0] uid;
        pick = $urandom_range(0, 99);
        if (pick < grant_pct)
            func = art_pkg::FUNC_GRANT;
        else if (pick < grant_pct + revoke_pct)
            func = art_pkg::FUNC_REVOKE;
        else if (pick < 95)
            func = art_pkg::FUNC_CHECK;
        else
            func = FUNC_UNUSED;
        if ($urandom_range(0, 99) < 85)
            uid = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            uid = $urandom;
        send_request(func, uid, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        sb = new;
        sb.set_owner(32'd0);
        uid_pool[0] = 32'h0000_0000;
        uid_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++) uid_pool[k] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            response_sink();
        join_none
        @(posedge i_clk);

        run_directed();

        // Phases alternate between grant-heavy (table mostly full) and
        // revoke-heavy traffic; owner moves between extremes, pool members and other ids.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       write_owner(32'hFFFF_FFFF);
                1:       write_owner(uid_pool[2]);
                2:       write_owner($urandom);
                3:       write_owner(32'h0000_0000);
                4:       write_owner(uid_pool[5]);
                default: write_owner(32'h8000_0000);
            endcase
            no_idle = (ph == 2);
            repeat (PHASE_ITEMS) begin
                if (ph % 2 == 0)
                    send_random(45, 15);
                else
                    send_random(25, 35);
            end
        end
        no_idle = 1'b0;
        i_s_tvalid <= 1'b0;

        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests / %0d responses over %0d owner settings",
                 sb.n_requests, sb.n_responses, owner_writes + 1);
        $display("grants dropped on a full table: %0d, checks allowed: %0d, mismatches: %0d",
                 sb.n_dropped, sb.n_allowed, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
